// ===== rtl/core/cpq_pkg.sv =====
`default_nettype none
package cpq_pkg;

  localparam int CoordW   = 16;
  localparam int DistW    = 32;
  localparam int NumCfg   = 8;
  localparam int CfgIdxW  = 4;
  localparam int NumEdges = 4;

  typedef enum logic [CfgIdxW-1:0] {
    RegTopLeftX     = 4'd0,
    RegTopLeftY     = 4'd1,
    RegTopRightX    = 4'd2,
    RegTopRightY    = 4'd3,
    RegBottomLeftX  = 4'd4,
    RegBottomLeftY  = 4'd5,
    RegBottomRightX = 4'd6,
    RegBottomRightY = 4'd7
  } cfg_reg_e;

  typedef struct packed {
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_y;
    logic                     last_point;
  } point_t;

  typedef struct packed {
    logic signed [CoordW-1:0] nearest_x;
    logic signed [CoordW-1:0] nearest_y;
    logic                     found;
  } result_t;

  typedef struct packed {
    logic signed [CoordW-1:0] tl_x;
    logic signed [CoordW-1:0] tl_y;
    logic signed [CoordW-1:0] tr_x;
    logic signed [CoordW-1:0] tr_y;
    logic signed [CoordW-1:0] bl_x;
    logic signed [CoordW-1:0] bl_y;
    logic signed [CoordW-1:0] br_x;
    logic signed [CoordW-1:0] br_y;
  } corners_t;

  // classified point handed from front to back
  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic                     hit;
    logic                     last;
    logic [DistW-1:0]         dist_sq;
  } item_t;

  typedef struct packed {
    logic valid;
    logic ready;
  } qstat_t;

endpackage
`default_nettype wire

// ===== rtl/core/cpq_front.sv =====
`default_nettype none
module cpq_front (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire cpq_pkg::corners_t corners_i,
  input  wire                    in_valid_i,
  output logic                   in_stall_o,
  input  wire cpq_pkg::point_t   in_data_i,
  output logic                   push_o,
  output cpq_pkg::item_t         push_data_o,
  input  wire                    push_ready_i
);

  localparam int CW   = cpq_pkg::CoordW;
  localparam int DW   = CW + 1;
  localparam int PW   = 2 * DW;
  localparam int XW   = PW + 1;
  localparam int SqW  = 2 * CW;
  localparam int SumW = SqW + 1;
  localparam int NE   = cpq_pkg::NumEdges;
  localparam int DstW = cpq_pkg::DistW;

  logic signed [CW-1:0] ax [NE];
  logic signed [CW-1:0] ay [NE];
  logic signed [CW-1:0] bx [NE];
  logic signed [CW-1:0] by [NE];

  always_comb begin
    ax[0] = corners_i.tl_x; ay[0] = corners_i.tl_y;
    bx[0] = corners_i.tr_x; by[0] = corners_i.tr_y;
    ax[1] = corners_i.tl_x; ay[1] = corners_i.tl_y;
    bx[1] = corners_i.bl_x; by[1] = corners_i.bl_y;
    ax[2] = corners_i.tr_x; ay[2] = corners_i.tr_y;
    bx[2] = corners_i.br_x; by[2] = corners_i.br_y;
    ax[3] = corners_i.bl_x; ay[3] = corners_i.bl_y;
    bx[3] = corners_i.br_x; by[3] = corners_i.br_y;
  end

  logic                 s1_valid_q;
  logic signed [PW-1:0] prod_a_q [NE];
  logic signed [PW-1:0] prod_b_q [NE];
  logic                 dir_q    [NE];
  logic                 span_q   [NE];
  logic [SqW-1:0]       sqx_q, sqy_q;
  logic                 ypos_q;
  logic signed [CW-1:0] x_q, y_q;
  logic                 last_q;

  logic s1_en;
  assign push_o     = s1_valid_q && push_ready_i;
  assign s1_en      = !s1_valid_q || push_ready_i;
  assign in_stall_o = !s1_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_en) begin
      s1_valid_q <= in_valid_i;
    end
  end

  logic signed [SqW-1:0] sqx_s, sqy_s;
  assign sqx_s = in_data_i.point_x * in_data_i.point_x;
  assign sqy_s = in_data_i.point_y * in_data_i.point_y;

  for (genvar e = 0; e < NE; e++) begin : g_edge
    logic signed [DW-1:0] dyab, dxpa, dypa, dxab;
    logic                 lt_ab, ge_a, lt_b, ge_b, lt_a;
    assign dyab  = DW'(by[e]) - DW'(ay[e]);
    assign dxpa  = DW'(in_data_i.point_x) - DW'(ax[e]);
    assign dypa  = DW'(in_data_i.point_y) - DW'(ay[e]);
    assign dxab  = DW'(bx[e]) - DW'(ax[e]);
    assign lt_ab = ax[e] < bx[e];
    assign ge_a  = in_data_i.point_x >= ax[e];
    assign lt_a  = in_data_i.point_x <  ax[e];
    assign ge_b  = in_data_i.point_x >= bx[e];
    assign lt_b  = in_data_i.point_x <  bx[e];

    always_ff @(posedge clk_i) begin
      if (s1_en) begin
        prod_a_q[e] <= dyab * dxpa;
        prod_b_q[e] <= dypa * dxab;
        dir_q[e]    <= lt_ab;
        // half-open span, vertical edges never match
        span_q[e]   <= lt_ab ? (ge_a && lt_b) : ((ax[e] != bx[e]) && ge_b && lt_a);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_en) begin
      sqx_q  <= unsigned'(sqx_s);
      sqy_q  <= unsigned'(sqy_s);
      ypos_q <= in_data_i.point_y > 0;
      x_q    <= in_data_i.point_x;
      y_q    <= in_data_i.point_y;
      last_q <= in_data_i.last_point;
    end
  end

  logic [NE-1:0]   crossed;
  logic [SumW-1:0] sum;

  always_comb begin
    logic signed [XW-1:0] diff;
    for (int e = 0; e < NE; e++) begin
      diff       = XW'(prod_a_q[e]) - XW'(prod_b_q[e]);
      crossed[e] = span_q[e] && (dir_q[e] ? (diff > 0) : (diff < 0));
    end
  end

  assign sum = SumW'(sqx_q) + SumW'(sqy_q);

  always_comb begin
    push_data_o.x    = x_q;
    push_data_o.y    = y_q;
    push_data_o.last = last_q;
    push_data_o.hit  = (^crossed) && ypos_q;
    if (sum > {{(SumW-DstW){1'b0}}, {DstW{1'b1}}}) begin
      push_data_o.dist_sq = {DstW{1'b1}};
    end else begin
      push_data_o.dist_sq = sum[DstW-1:0];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/cpq_fifo.sv =====
`default_nettype none
module cpq_fifo (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  push_i,
  input  wire cpq_pkg::item_t  push_data_i,
  input  wire                  pop_i,
  output cpq_pkg::qstat_t      stat_o,
  output cpq_pkg::item_t       head_o
);

  localparam int Depth = 4;
  localparam int PtrW  = $clog2(Depth);
  localparam int CntW  = PtrW + 1;

  cpq_pkg::item_t  mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign stat_o.valid = count_q != '0;
  assign stat_o.ready = count_q != CntW'(Depth);
  assign head_o       = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/cpq_back.sv =====
`default_nettype none
module cpq_back (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire cpq_pkg::qstat_t stat_i,
  input  wire cpq_pkg::item_t  head_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output cpq_pkg::result_t     out_data_o
);

  localparam int CW   = cpq_pkg::CoordW;
  localparam int DstW = cpq_pkg::DistW;

  logic signed [CW-1:0] best_x_q, best_y_q;
  logic [DstW-1:0]      best_d_q;
  logic                 have_best_q;
  logic                 out_valid_q;
  cpq_pkg::result_t     out_data_q;

  logic                 better;
  logic signed [CW-1:0] upd_x, upd_y;
  logic                 upd_have;

  assign pop_o  = stat_i.valid && !(head_i.last && out_valid_q && out_stall_i);
  assign better = head_i.hit && (!have_best_q || head_i.dist_sq < best_d_q);
  assign upd_x    = better ? head_i.x : best_x_q;
  assign upd_y    = better ? head_i.y : best_y_q;
  assign upd_have = better || have_best_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_x_q    <= '0;
      best_y_q    <= '0;
      best_d_q    <= '1;
      have_best_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o && head_i.last) begin
        best_x_q    <= '0;
        best_y_q    <= '0;
        best_d_q    <= '1;
        have_best_q <= 1'b0;
        out_valid_q <= 1'b1;
      end else begin
        if (pop_o && better) begin
          best_x_q    <= head_i.x;
          best_y_q    <= head_i.y;
          best_d_q    <= head_i.dist_sq;
          have_best_q <= 1'b1;
        end
        if (!out_stall_i) out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && head_i.last) begin
      out_data_q.nearest_x <= upd_have ? upd_x : '0;
      out_data_q.nearest_y <= upd_have ? upd_y : '0;
      out_data_q.found     <= upd_have;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && head_i.last) |=> !have_best_q && best_d_q == '1)
    else $error("scan state not cleared after last point");

  a_best_positive_y: assert property (@(posedge clk_i) disable iff (!rst_ni)
    have_best_q |-> best_y_q > 0)
    else $error("kept point has non-positive y");

  a_empty_dist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !have_best_q |-> best_d_q == '1)
    else $error("distance not at reset value while nothing kept");

  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_data_q.found) |->
      (out_data_q.nearest_x == '0 && out_data_q.nearest_y == '0))
    else $error("nonzero coordinates on empty result");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> stat_i.valid)
    else $error("pop from empty queue");

endmodule
`default_nettype wire

// ===== rtl/core/closest_point_in_quadrilateral.sv =====
`default_nettype none
// channel  | handshake                 | payload
// ---------+---------------------------+-----------------------------------
// in       | in_valid_i / in_stall_o   | cpq_pkg::point_t  (x, y, last)
// out      | out_valid_o / out_stall_i | cpq_pkg::result_t (x, y, found)
// cfg      | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// One point per cycle sustained while the queue has room. An accepted point is
// registered with its edge products and squares; from those registers parity,
// compare and distance are formed and it is written into a 4-entry queue. The
// back pops it and updates the running minimum; a last point loads the result
// register at the same edge as its pop, and out_valid_o is set at that edge too.
// A stalled result only holds back the next last point; other points keep
// flowing until the queue fills. Reset clears corners to zero and the scan
// state to empty; no clearing pass.
module closest_point_in_quadrilateral (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 in_valid_i,
  output logic                                in_stall_o,
  input  wire cpq_pkg::point_t                in_data_i,
  output logic                                out_valid_o,
  input  wire                                 out_stall_i,
  output cpq_pkg::result_t                    out_data_o,
  input  wire                                 cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire [cpq_pkg::CfgIdxW-1:0]          cfg_index_i,
  input  wire signed [cpq_pkg::CoordW-1:0]    cfg_data_i
);

  cpq_pkg::corners_t corners_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      corners_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        cpq_pkg::RegTopLeftX:     corners_q.tl_x <= cfg_data_i;
        cpq_pkg::RegTopLeftY:     corners_q.tl_y <= cfg_data_i;
        cpq_pkg::RegTopRightX:    corners_q.tr_x <= cfg_data_i;
        cpq_pkg::RegTopRightY:    corners_q.tr_y <= cfg_data_i;
        cpq_pkg::RegBottomLeftX:  corners_q.bl_x <= cfg_data_i;
        cpq_pkg::RegBottomLeftY:  corners_q.bl_y <= cfg_data_i;
        cpq_pkg::RegBottomRightX: corners_q.br_x <= cfg_data_i;
        cpq_pkg::RegBottomRightY: corners_q.br_y <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic            push;
  cpq_pkg::item_t  push_data;
  logic            pop;
  cpq_pkg::qstat_t qstat;
  cpq_pkg::item_t  head;

  cpq_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .corners_i    (corners_q),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .push_o       (push),
    .push_data_o  (push_data),
    .push_ready_i (qstat.ready)
  );

  cpq_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .stat_o      (qstat),
    .head_o      (head)
  );

  cpq_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .stat_i      (qstat),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire

// ===== tb/cpq_checker.sv =====
`timescale 1ns / 1ps
module cpq_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_stall_i,
  input  cpq_pkg::point_t                   in_data_i,
  input  logic                              out_valid_i,
  input  logic                              out_stall_i,
  input  cpq_pkg::result_t                  out_data_i,
  input  logic                              cfg_valid_i,
  input  logic                              cfg_ready_i,
  input  logic [cpq_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic signed [cpq_pkg::CoordW-1:0] cfg_data_i,
  output int                                errors_o,
  output int                                pending_o
);

  localparam int     NumCfg  = cpq_pkg::NumCfg;
  localparam int     CoordW  = cpq_pkg::CoordW;
  localparam int     DistW   = cpq_pkg::DistW;
  localparam longint DistMax = 64'hFFFF_FFFF;

  logic signed [CoordW-1:0] corner_q [NumCfg];
  logic signed [CoordW-1:0] best_x_q = '0;
  logic signed [CoordW-1:0] best_y_q = '0;
  logic [DistW-1:0]         best_dist_q = '1;
  logic                     has_best_q = 1'b0;
  cpq_pkg::result_t         nearest_q [$];
  int                       errors = 0;
  int                       pending = 0;

  assign errors_o  = errors;
  assign pending_o = pending;

  // upward ray from (px, py) against edge a-b; half-open x span, strict below
  function automatic bit ray_crosses_edge(input longint px, input longint py,
                                          input longint ax, input longint ay,
                                          input longint bx, input longint by);
    longint lo_x, lo_y, hi_x, hi_y;
    lo_x = (ax < bx) ? ax : bx;
    lo_y = (ax < bx) ? ay : by;
    hi_x = (ax < bx) ? bx : ax;
    hi_y = (ax < bx) ? by : ay;
    if (ax == bx || px < lo_x || px >= hi_x) return 1'b0;
    return (hi_y - lo_y) * (px - lo_x) > (py - lo_y) * (hi_x - lo_x);
  endfunction

  task automatic track_point(input cpq_pkg::point_t p);
    longint           c [NumCfg];
    longint           px, py, sq;
    logic [DistW-1:0] dist_sq;
    int               crossings;
    cpq_pkg::result_t r;
    for (int i = 0; i < NumCfg; i++) c[i] = corner_q[i];
    px = $signed(p.point_x);
    py = $signed(p.point_y);
    crossings = 0;
    if (ray_crosses_edge(px, py, c[cpq_pkg::RegTopLeftX], c[cpq_pkg::RegTopLeftY],
                         c[cpq_pkg::RegTopRightX], c[cpq_pkg::RegTopRightY]))
      crossings++;
    if (ray_crosses_edge(px, py, c[cpq_pkg::RegTopLeftX], c[cpq_pkg::RegTopLeftY],
                         c[cpq_pkg::RegBottomLeftX], c[cpq_pkg::RegBottomLeftY]))
      crossings++;
    if (ray_crosses_edge(px, py, c[cpq_pkg::RegTopRightX], c[cpq_pkg::RegTopRightY],
                         c[cpq_pkg::RegBottomRightX], c[cpq_pkg::RegBottomRightY]))
      crossings++;
    if (ray_crosses_edge(px, py, c[cpq_pkg::RegBottomLeftX], c[cpq_pkg::RegBottomLeftY],
                         c[cpq_pkg::RegBottomRightX], c[cpq_pkg::RegBottomRightY]))
      crossings++;
    if (crossings[0] && py > 0) begin
      sq      = px * px + py * py;
      dist_sq = (sq > DistMax) ? '1 : DistW'(sq);
      if (!has_best_q || dist_sq < best_dist_q) begin
        best_dist_q = dist_sq;
        best_x_q    = p.point_x;
        best_y_q    = p.point_y;
        has_best_q  = 1'b1;
      end
    end
    if (p.last_point) begin
      r = '0;
      if (has_best_q) begin
        r.nearest_x = best_x_q;
        r.nearest_y = best_y_q;
        r.found     = 1'b1;
      end
      nearest_q.insert(nearest_q.size(), r);
      best_x_q    = '0;
      best_y_q    = '0;
      best_dist_q = '1;
      has_best_q  = 1'b0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    cpq_pkg::result_t want;
    if (!rst_ni) begin
      for (int i = 0; i < NumCfg; i++) corner_q[i] = '0;
      best_x_q    = '0;
      best_y_q    = '0;
      best_dist_q = '1;
      has_best_q  = 1'b0;
      nearest_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i && cfg_index_i < NumCfg) begin
        corner_q[cfg_index_i] = cfg_data_i;
      end
      if (out_valid_i && !out_stall_i) begin
        if (nearest_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, got x=%0d y=%0d found=%0b",
                   $time, out_data_i.nearest_x, out_data_i.nearest_y,
                   out_data_i.found);
        end else begin
          want = nearest_q.pop_front();
          if (out_data_i.nearest_x !== want.nearest_x ||
              out_data_i.nearest_y !== want.nearest_y ||
              out_data_i.found !== want.found) begin
            errors++;
            $display({"%0t: result mismatch, expected x=%0d y=%0d found=%0b, ",
                      "got x=%0d y=%0d found=%0b"},
                     $time, want.nearest_x, want.nearest_y, want.found,
                     out_data_i.nearest_x, out_data_i.nearest_y, out_data_i.found);
          end
        end
      end
      if (in_valid_i && !in_stall_i) track_point(in_data_i);
    end
    pending = nearest_q.size();
  end

endmodule

// ===== tb/closest_point_in_quadrilateral_tb.sv =====
`timescale 1ns / 1ps
module closest_point_in_quadrilateral_tb;

  localparam int Period      = 8;
  localparam int DrainCycles = 24;
  localparam int CycleLimit  = 400000;
  localparam int RandomItems = 700;
  localparam int NumCfg      = cpq_pkg::NumCfg;
  localparam int CoordW      = cpq_pkg::CoordW;
  localparam int CfgIdxW     = cpq_pkg::CfgIdxW;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  cpq_pkg::point_t          in_data = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  cpq_pkg::result_t         out_data;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CfgIdxW-1:0]       cfg_index = '0;
  logic signed [CoordW-1:0] cfg_data = '0;
  int                       errors;
  int                       pending;
  int                       cycles = 0;
  int                       items_sent = 0;
  int                       in_idle_pct = 0;
  int                       out_stall_pct = 0;
  logic signed [CoordW-1:0] corner_set [NumCfg];

  closest_point_in_quadrilateral u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  cpq_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  always #(Period / 2) clk = ~clk;

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < out_stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic int rand_between(input int lo, input int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  function automatic logic signed [CoordW-1:0] clamp_coord(input int v);
    if (v < -32768) return -16'sd32768;
    if (v > 32767) return 16'sd32767;
    return CoordW'(v);
  endfunction

  function automatic cpq_pkg::point_t pt(input int x, input int y, input bit last);
    cpq_pkg::point_t p;
    p.point_x    = clamp_coord(x);
    p.point_y    = clamp_coord(y);
    p.last_point = last;
    return p;
  endfunction

  function automatic void set_box(input int x_lo, input int x_hi, input int y_lo,
                                  input int y_hi, input int jitter);
    corner_set[cpq_pkg::RegTopLeftX]     = clamp_coord(x_lo + rand_between(-jitter, jitter));
    corner_set[cpq_pkg::RegTopLeftY]     = clamp_coord(y_hi + rand_between(-jitter, jitter));
    corner_set[cpq_pkg::RegTopRightX]    = clamp_coord(x_hi + rand_between(-jitter, jitter));
    corner_set[cpq_pkg::RegTopRightY]    = clamp_coord(y_hi + rand_between(-jitter, jitter));
    corner_set[cpq_pkg::RegBottomLeftX]  = clamp_coord(x_lo + rand_between(-jitter, jitter));
    corner_set[cpq_pkg::RegBottomLeftY]  = clamp_coord(y_lo + rand_between(-jitter, jitter));
    corner_set[cpq_pkg::RegBottomRightX] = clamp_coord(x_hi + rand_between(-jitter, jitter));
    corner_set[cpq_pkg::RegBottomRightY] = clamp_coord(y_lo + rand_between(-jitter, jitter));
  endfunction

  function automatic void pick_corners();
    int                       kind, x_lo, y_lo;
    logic signed [CoordW-1:0] pair [4];
    kind = $urandom_range(0, 9);
    if (kind < 6) begin
      x_lo = rand_between(-30000, 20000);
      y_lo = rand_between(-20000, 20000);
      set_box(x_lo, x_lo + rand_between(1, 10000), y_lo, y_lo + rand_between(1, 12000), 64);
    end else if (kind < 8) begin
      for (int i = 0; i < NumCfg; i++) corner_set[i] = CoordW'($urandom());
    end else if (kind == 8) begin
      for (int i = 0; i < NumCfg; i++) begin
        case ($urandom_range(0, 2))
          0: corner_set[i] = -16'sd32768;
          1: corner_set[i] = 16'sd0;
          default: corner_set[i] = 16'sd32767;
        endcase
      end
    end else begin
      // coinciding corners: every corner is one of two points
      for (int i = 0; i < 4; i++) pair[i] = CoordW'($urandom());
      for (int c = 0; c < NumCfg; c += 2) begin
        if ($urandom_range(0, 1)) begin
          corner_set[c]     = pair[0];
          corner_set[c + 1] = pair[1];
        end else begin
          corner_set[c]     = pair[2];
          corner_set[c + 1] = pair[3];
        end
      end
    end
  endfunction

  function automatic cpq_pkg::point_t pick_point(input bit last);
    int              x_lo, x_hi, y_lo, y_hi, r;
    cpq_pkg::point_t p;
    x_lo = 32767;
    x_hi = -32768;
    y_lo = 32767;
    y_hi = -32768;
    for (int c = 0; c < NumCfg; c += 2) begin
      if (corner_set[c] < x_lo) x_lo = int'(corner_set[c]);
      if (corner_set[c] > x_hi) x_hi = int'(corner_set[c]);
      if (corner_set[c + 1] < y_lo) y_lo = int'(corner_set[c + 1]);
      if (corner_set[c + 1] > y_hi) y_hi = int'(corner_set[c + 1]);
    end
    p = pt(rand_between(x_lo - 2, x_hi + 2), rand_between(y_lo - 2, y_hi + 2), last);
    r = $urandom_range(0, 99);
    if (r < 15) begin
      p.point_x = corner_set[2 * $urandom_range(0, 3)];
    end else if (r < 25) begin
      p.point_y = corner_set[2 * $urandom_range(0, 3) + 1];
    end else if (r < 45) begin
      p.point_x = CoordW'($urandom());
      p.point_y = CoordW'($urandom());
    end
    return p;
  endfunction

  task automatic send_point(input cpq_pkg::point_t p);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_scan(input int len);
    for (int k = 0; k < len; k++) send_point(pick_point(k == len - 1));
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx,
                           input logic signed [CoordW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic load_corners(input bit with_stray);
    for (int i = 0; i < NumCfg; i++) write_reg(CfgIdxW'(i), corner_set[i]);
    // index past the corner registers must be ignored
    if (with_stray) begin
      write_reg(CfgIdxW'(rand_between(NumCfg, (1 << CfgIdxW) - 1)), CoordW'($urandom()));
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  initial begin
    int target;
    in_idle_pct   = 13;
    out_stall_pct = 56;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset corners: all edges vertical, nothing inside
    send_point(pt(100, 100, 0));
    send_point(pt(32767, 32767, 1));
    wait_drain();

    set_box(-1000, 1000, -500, 1000, 0);
    load_corners(1'b0);
    send_point(pt(0, 0, 0));
    send_point(pt(500, 800, 0));
    send_point(pt(-1000, 300, 0));
    send_point(pt(1000, 300, 0));
    send_point(pt(0, 1000, 0));
    send_point(pt(300, -500, 0));
    send_point(pt(0, 1500, 0));
    send_point(pt(300, 400, 0));
    send_point(pt(400, 300, 0));
    send_point(pt(-400, 300, 1));
    send_point(pt(0, 1001, 0));
    send_point(pt(-32768, -32768, 0));
    send_point(pt(32767, 32767, 1));
    send_point(pt(1, 1, 1));
    wait_drain();

    set_box(-32768, 32767, -32768, 32767, 0);
    load_corners(1'b1);
    send_point(pt(-32768, 32766, 0));
    send_point(pt(32766, 1, 0));
    send_point(pt(-32768, 1, 0));
    send_point(pt(0, 32767, 0));
    send_point(pt(32767, 100, 0));
    send_point(pt(-1, -1, 1));
    wait_drain();

    for (int mode = 0; mode < 3; mode++) begin
      in_idle_pct   = (mode == 0) ? 13 : (mode == 1) ? 56 : 0;
      out_stall_pct = (mode == 0) ? 56 : (mode == 1) ? 13 : 0;
      for (int n = 0; n < 3; n++) begin
        pick_corners();
        load_corners($urandom_range(0, 3) == 0);
        target = items_sent + RandomItems / 9;
        while (items_sent < target) send_scan($urandom_range(1, 16));
        wait_drain();
      end
    end

    if (errors == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
